// ===== sv/xkb_pkg.sv =====
// ----------------------------------------------------------------------------
// xkb_pkg
// Shared types, register indexes and the Base64 alphabet for the keyed
// Base64 encoder.
// ----------------------------------------------------------------------------
package xkb_pkg;

    typedef logic [6:0] t_char;

    // One queue entry: every character caused by one input byte.
    typedef struct packed {
        t_char [3:0] chars;
        logic  [1:0] cnt_m1;   // number of characters minus one
    } t_xkb_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_xkb_qstat;

    localparam int unsigned CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LENGTH = 3'd4;

    // residue size codes
    localparam logic [1:0] RES_0 = 2'd0;
    localparam logic [1:0] RES_2 = 2'd1;
    localparam logic [1:0] RES_4 = 2'd2;

    localparam t_char CHAR_PAD = 7'h3D;   // '='

    function automatic t_char b64_char(input logic [5:0] v);
        t_char c;
        if (v < 6'd26) begin
            c = 7'(v) + 7'h41;
        end else if (v < 6'd52) begin
            c = 7'(v - 6'd26) + 7'h61;
        end else if (v < 6'd62) begin
            c = 7'(v - 6'd52) + 7'h30;
        end else if (v == 6'd62) begin
            c = 7'h2B;
        end else begin
            c = 7'h2F;
        end
        return c;
    endfunction

endpackage

// ===== sv/xkb_front.sv =====
// ----------------------------------------------------------------------------
// xkb_front
// Key store, XOR with the running key byte, and Base64 grouping of one byte
// into a queue entry of one to four characters.
// ----------------------------------------------------------------------------
module xkb_front import xkb_pkg::*; #(
    parameter int unsigned KEY_BYTES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [63:0]           i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_end_of_message,
    input  t_xkb_qstat            i_qstat,
    output logic                  o_push,
    output t_xkb_entry            o_entry
);

    localparam int unsigned PW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    logic [KEY_BYTES-1:0][7:0] r_key;
    logic [5:0]                r_key_len;
    logic [PW-1:0]             r_pos,   n_pos;
    logic [3:0]                r_res,   n_res;
    logic [1:0]                r_res_sz, n_res_sz;
    logic [1:0]                r_phase, n_phase;

    logic [5:0] eff_len;
    logic [7:0] keyed;
    logic [5:0] c0, c1;
    logic [3:0] res_new;
    logic [1:0] sz_new;
    logic [1:0] num_chars;
    logic       has_c1;
    logic [5:0] flush;
    logic [1:0] phase_after;
    logic [2:0] pad_need, pad_lim, pads, total;

    // key bytes beyond KEY_BYTES are never addressed, so they are not kept
    for (genvar b = 0; b < KEY_BYTES; b++) begin : g_key
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_key[b] <= 8'd0;
            end else if (i_cfg_we && i_cfg_addr == CFG_KEY_WORD_0 + 3'(b / 8)) begin
                r_key[b] <= i_cfg_wdata[(b % 8) * 8 +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= 6'd1;
        end else if (i_cfg_we && i_cfg_addr == CFG_KEY_LENGTH) begin
            r_key_len <= i_cfg_wdata[5:0];
        end
    end

    assign o_in_ready = !i_qstat.full;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        if (r_key_len == 6'd0) begin
            eff_len = 6'd1;
        end else if (r_key_len > 6'(KEY_BYTES)) begin
            eff_len = 6'(KEY_BYTES);
        end else begin
            eff_len = r_key_len;
        end
    end

    assign keyed = i_data_byte ^ r_key[r_pos];

    always_comb begin
        c1 = keyed[5:0];
        case (r_res_sz)
            RES_0: begin
                c0      = keyed[7:2];
                res_new = {2'b00, keyed[1:0]};
                sz_new  = RES_2;
                has_c1  = 1'b0;
            end
            RES_2: begin
                c0      = {r_res[1:0], keyed[7:4]};
                res_new = keyed[3:0];
                sz_new  = RES_4;
                has_c1  = 1'b0;
            end
            default: begin
                c0      = {r_res, keyed[7:6]};
                res_new = 4'd0;
                sz_new  = RES_0;
                has_c1  = 1'b1;
            end
        endcase
    end

    // flush of leftover bits, zero filled on the right
    always_comb begin
        case (sz_new)
            RES_2:   flush = {res_new[1:0], 4'b0000};
            RES_4:   flush = {res_new, 2'b00};
            default: flush = 6'd0;
        endcase
    end

    always_comb begin
        num_chars = has_c1 ? 2'd2 : 2'd1;
        o_entry.chars    = {4{CHAR_PAD}};
        o_entry.chars[0] = b64_char(c0);
        if (has_c1) begin
            o_entry.chars[1] = b64_char(c1);
        end else if (i_end_of_message && sz_new != RES_0) begin
            o_entry.chars[1] = b64_char(flush);
            num_chars = 2'd2;
        end
        phase_after = r_phase + num_chars;
        pad_need    = 3'd4 - {1'b0, phase_after};
        pad_need    = {1'b0, pad_need[1:0]};
        pad_lim     = 3'd4 - {1'b0, num_chars};
        pads        = (pad_need < pad_lim) ? pad_need : pad_lim;
        total       = {1'b0, num_chars} + (i_end_of_message ? pads : 3'd0);
        o_entry.cnt_m1 = 2'(total - 3'd1);
    end

    always_comb begin
        n_pos    = r_pos;
        n_res    = r_res;
        n_res_sz = r_res_sz;
        n_phase  = r_phase;
        if (o_push) begin
            if (i_end_of_message) begin
                n_pos    = '0;
                n_res    = 4'd0;
                n_res_sz = RES_0;
                n_phase  = 2'd0;
            end else begin
                n_pos    = (7'(r_pos) + 7'd1 >= 7'(eff_len)) ? '0 : PW'(7'(r_pos) + 7'd1);
                n_res    = res_new;
                n_res_sz = sz_new;
                n_phase  = phase_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_res    <= 4'd0;
            r_res_sz <= RES_0;
            r_phase  <= 2'd0;
        end else begin
            r_pos    <= n_pos;
            r_res    <= n_res;
            r_res_sz <= n_res_sz;
            r_phase  <= n_phase;
        end
    end

endmodule

// ===== sv/xkb_queue.sv =====
// ----------------------------------------------------------------------------
// xkb_queue
// Two-entry show-ahead queue of character groups between front and back.
// ----------------------------------------------------------------------------
module xkb_queue import xkb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_xkb_entry i_entry,
    input  logic       i_pop,
    output t_xkb_entry o_entry,
    output t_xkb_qstat o_stat
);

    t_xkb_entry r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_entry      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

endmodule

// ===== sv/xkb_back.sv =====
// ----------------------------------------------------------------------------
// xkb_back
// Output register: plays out one queued character group, one per beat.
// ----------------------------------------------------------------------------
module xkb_back import xkb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_xkb_entry i_entry,
    input  t_xkb_qstat i_qstat,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_char      o_out_char,
    output logic       o_last_char
);

    t_xkb_entry r_entry;
    logic [1:0] r_idx;
    logic       r_busy;

    assign o_out_valid = r_busy;
    assign o_out_char  = r_entry.chars[r_idx];
    assign o_last_char = (r_idx == r_entry.cnt_m1);

    // load the next group when idle or as the last char of this one leaves
    assign o_pop = !i_qstat.empty && (!r_busy || (i_out_ready && o_last_char));

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (r_busy && i_out_ready) begin
            if (o_last_char) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

// ===== sv/xor_key_base64_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// xor_key_base64_encoder_unit
// Repeating-key XOR followed by Base64 encoding with '=' padding at message end.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------
//  in      | sink      | i_in_valid / o_in_ready  | i_data_byte, i_end_of_message
//  out     | source    | o_out_valid / i_out_ready| o_out_char, o_last_char
//  cfg     | sink      | i_cfg_we                 | i_cfg_addr, i_cfg_wdata
//
//  One output char per cycle while i_out_ready is high and a group is queued;
//  a byte yields one to four chars, about 4/3 per byte on a long message.
//  The front takes a byte per cycle while the two-entry queue has room.
//  A taken byte is written into the queue, then loaded into the output register,
//  which raises o_out_valid. Synchronous reset clears key, position, residue,
//  queue and output; key length resets to 1. A stalled sink backs up to o_in_ready.
// ----------------------------------------------------------------------------
module xor_key_base64_encoder_unit import xkb_pkg::*; #(
    parameter int unsigned KEY_BYTES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [63:0]           i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_end_of_message,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [6:0]            o_out_char,
    output logic                  o_last_char
);

    logic       push, pop;
    t_xkb_entry push_entry, head_entry;
    t_xkb_qstat qstat;

    xkb_front #(
        .KEY_BYTES (KEY_BYTES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_qstat          (qstat),
        .o_push           (push),
        .o_entry          (push_entry)
    );

    xkb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_stat  (qstat)
    );

    xkb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (head_entry),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty at once");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && qstat.empty && !o_out_valid) |=> ##1 o_out_valid)
        else $error("byte taken into an idle unit produced no beat");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

endmodule
